/* rtl/core/mct_pkg.sv */
// ----------------------------------------------------------------------------
// mct_pkg
// shared types and constants for the multiset counting table
// ----------------------------------------------------------------------------
`default_nettype none

package mct_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SCAN_W  = IDX_W + 1;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 31;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REM_ONE = 2'd1,
        OP_REM_ALL = 2'd2,
        OP_QUERY   = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic signed [KEY_W-1:0]  key;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count_after;
        logic               key_present;
        logic               table_full;
    } out_item_t;

    // one table word
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [COUNT_W-1:0]      count;
    } entry_t;

    // control from the front end to the table engine
    typedef struct packed {
        logic start;
        logic res_ready;
    } mct_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/mct_engine.sv */
// ----------------------------------------------------------------------------
// mct_engine
// table memory, valid bits, linear search and read-modify-write update
// ----------------------------------------------------------------------------
`default_nettype none

module mct_engine (
    input  wire                  clk,
    input  wire                  rst_n,
    input  mct_pkg::mct_ctl_t    ctl,
    input  mct_pkg::in_item_t    req,
    output logic                 res_valid,
    output mct_pkg::out_item_t   res
);
    import mct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(ENTRIES);

    entry_t               mem [ENTRIES];
    entry_t               rd_data_reg;
    logic [ENTRIES-1:0]   entry_valid_reg, entry_valid_next;

    state_t               state_reg, state_next;
    logic [SCAN_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic                 free_reg, free_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;

    logic                 issue;
    logic [IDX_W-1:0]     rd_addr;
    logic                 cmp_hit, cmp_free;
    logic                 upd_fire;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [COUNT_W-1:0]   new_cnt;
    logic                 set_valid, clr_valid;
    logic                 full;

    assign issue   = (state_reg == S_SCAN) && !hit_reg && (scan_cnt_reg != SCAN_END);
    assign rd_addr = scan_cnt_reg[IDX_W-1:0];

    assign cmp_hit  = cmp_vld_reg && !hit_reg && entry_valid_reg[cmp_idx_reg]
                      && (rd_data_reg.key == req.key);
    assign cmp_free = cmp_vld_reg && !free_reg && !entry_valid_reg[cmp_idx_reg];

    assign upd_fire = (state_reg == S_UPDATE) && ctl.res_ready;

    // update decision from the search outcome
    always_comb
    begin
        wr_en     = 1'b0;
        wr_idx    = hit_idx_reg;
        new_cnt   = '0;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        full      = 1'b0;
        unique case (req.opcode)
            OP_ADD:
            begin
                if (hit_reg)
                begin
                    new_cnt = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg
                                                         : hit_cnt_reg + COUNT_W'(1);
                    wr_en   = 1'b1;
                end
                else if (free_reg)
                begin
                    new_cnt   = COUNT_W'(1);
                    wr_en     = 1'b1;
                    wr_idx    = free_idx_reg;
                    set_valid = 1'b1;
                end
                else
                begin
                    full = 1'b1;
                end
            end
            OP_REM_ONE:
            begin
                if (hit_reg)
                begin
                    new_cnt   = (hit_cnt_reg != '0) ? hit_cnt_reg - COUNT_W'(1) : '0;
                    wr_en     = 1'b1;
                    clr_valid = (new_cnt == '0);
                end
            end
            OP_REM_ALL:
            begin
                clr_valid = hit_reg;
            end
            OP_QUERY:
            begin
                if (hit_reg)
                begin
                    new_cnt = hit_cnt_reg;
                end
            end
        endcase
    end

    assign res_valid       = upd_fire;
    assign res.count_after = new_cnt;
    assign res.key_present = hit_reg;
    assign res.table_full  = full;

    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        if (upd_fire && set_valid)
        begin
            entry_valid_next[wr_idx] = 1'b1;
        end
        if (upd_fire && clr_valid)
        begin
            entry_valid_next[hit_idx_reg] = 1'b0;
        end
    end

    // search sequencer
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_vld_next  = issue;
        cmp_idx_next  = rd_addr;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_cnt_next  = hit_cnt_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;

        if (cmp_hit)
        begin
            hit_next     = 1'b1;
            hit_idx_next = cmp_idx_reg;
            hit_cnt_next = rd_data_reg.count;
        end
        if (cmp_free)
        begin
            free_next     = 1'b1;
            free_idx_next = cmp_idx_reg;
        end
        if (issue)
        begin
            scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next    = S_SCAN;
                    scan_cnt_next = '0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (hit_reg || ((scan_cnt_reg == SCAN_END) && !cmp_vld_reg))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (ctl.res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            scan_cnt_reg    <= '0;
            cmp_vld_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            free_reg        <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_cnt_reg    <= scan_cnt_next;
            cmp_vld_reg     <= cmp_vld_next;
            hit_reg         <= hit_next;
            free_reg        <= free_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        free_idx_reg <= free_idx_next;
    end

    // table memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (upd_fire && wr_en)
        begin
            mem[wr_idx] <= '{key: req.key, count: new_cnt};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // a located entry is still live when the update runs
    a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) && hit_reg |-> entry_valid_reg[hit_idx_reg])
        else $error("matched entry not valid at update");

    // a full table is only reported when no key was found and counts are zero
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.table_full |-> !res.key_present && (res.count_after == '0))
        else $error("table full with a live result");

    // insert of a new key occupies the chosen free entry
    a_insert_sets: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hit_reg && free_reg && (req.opcode == OP_ADD)
        |=> entry_valid_reg[$past(free_idx_reg)])
        else $error("inserted entry not marked valid");

    // remove-all frees the matched entry
    a_remove_all_frees: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && hit_reg && (req.opcode == OP_REM_ALL)
        |=> !entry_valid_reg[$past(hit_idx_reg)])
        else $error("remove-all left entry valid");

    // search never runs past the end of the table
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= SCAN_END)
        else $error("scan counter out of range");

endmodule

`default_nettype wire

/* rtl/core/multiset_count_table_unit.sv */
// ----------------------------------------------------------------------------
// multiset_count_table_unit
// fixed-capacity multiset of 32-bit keys with a saturating count per key
//
// search: from entry 0, stopping at the first match or after the last entry;
//   the single memory read port steps one entry per cycle
// items: one in flight; the next is taken once the engine hands over its result,
//   so the search length and back-pressure at the result register set the rate
// reset: all entries invalid at once (valid flops), no clearing pass needed
// ----------------------------------------------------------------------------
`default_nettype none

module multiset_count_table_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_ready,
    input  mct_pkg::in_item_t   item,
    output logic                result_valid,
    input  wire                 result_ready,
    output mct_pkg::out_item_t  result
);
    import mct_pkg::*;

    // front end: one item in flight, held stable for the engine
    logic       busy_reg, busy_next;
    in_item_t   req_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg;

    mct_ctl_t   ctl;
    logic       eng_res_valid;
    out_item_t  eng_res;
    logic       item_xfer;

    assign item_ready = !busy_reg;
    assign item_xfer  = item_valid && item_ready;

    // engine may finish when the output register is empty or draining
    assign ctl.start     = item_xfer;
    assign ctl.res_ready = !out_valid_reg || result_ready;

    mct_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req       (req_reg),
        .res_valid (eng_res_valid),
        .res       (eng_res)
    );

    // busy from item transfer until the engine hands over its result
    always_comb
    begin
        busy_next = busy_reg;
        if (item_xfer)
        begin
            busy_next = 1'b1;
        end
        else if (eng_res_valid)
        begin
            busy_next = 1'b0;
        end
    end

    // output register: a waiting result does not stop the next item
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (eng_res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            req_reg <= item;
        end
        if (eng_res_valid)
        begin
            out_reg <= eng_res;
        end
    end

    // engine only returns a result for an item in flight
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        eng_res_valid |-> busy_reg)
        else $error("engine result with no item in flight");

    // engine never overwrites a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        eng_res_valid |-> !out_valid_reg || result_ready)
        else $error("result register overwritten");

    // after a result is handed over the unit is free for the next item
    a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
        eng_res_valid |=> item_ready)
        else $error("unit not ready after result");

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for multiset_count_table_unit: a cycle-free model of
// the bag predicts each result at the item transfer, a checker process compares
// every result transfer in order, and both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mct_pkg::*;

    typedef logic signed [KEY_W-1:0] key_t;

    localparam key_t KEY_MIN    = 32'sh8000_0000;
    localparam key_t KEY_MAX    = 32'sh7FFF_FFFF;
    // the idle limit is well above the worst case per item (a full-table search plus
    // idling on both channels) and above the long receiver hold-off
    localparam int   IDLE_LIMIT = 2000;
    localparam int   HOLD_CYCLES = 300;
    // quiet tail, longer than a full-table search
    localparam int   TAIL_CYCLES = 80;

    // dut signals; the inputs are at known values from time zero
    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    // predicted copy of the bag
    logic                bag_valid [ENTRIES];
    key_t                bag_key   [ENTRIES];
    logic [COUNT_W-1:0]  bag_count [ENTRIES];

    // results predicted at the item transfer, oldest first
    out_item_t pending_results [$];
    key_t      key_pool [$];

    int   fail_count   = 0;
    int   sent_count   = 0;
    int   next_gap     = 0;
    bit   valid_held   = 1'b0;
    logic no_idle      = 1'b0;
    logic hold_results = 1'b0;

    multiset_count_table_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // bag model
    // ------------------------------------------------------------------

    // lowest valid entry holding k, -1 when absent
    function automatic int find_held(input key_t k);
        int i;
        for (i = 0; i < ENTRIES; i++)
            if (bag_valid[i] && bag_key[i] == k)
                return i;
        return -1;
    endfunction

    // lowest free entry, -1 when every entry is taken
    function automatic int find_free();
        int i;
        for (i = 0; i < ENTRIES; i++)
            if (!bag_valid[i])
                return i;
        return -1;
    endfunction

    function automatic int count_free();
        int i;
        int n;
        n = 0;
        for (i = 0; i < ENTRIES; i++)
            if (!bag_valid[i])
                n++;
        return n;
    endfunction

    // applies one item to the model bag and returns the result it causes
    function automatic out_item_t predict_result(input in_item_t it);
        out_item_t r;
        int        hit;
        int        slot;
        r   = '0;
        hit = find_held(it.key);
        r.key_present = (hit >= 0);
        case (it.opcode)
            OP_ADD:
            begin
                if (hit >= 0)
                begin
                    // saturating count
                    if (bag_count[hit] != COUNT_MAX)
                        bag_count[hit] = bag_count[hit] + COUNT_W'(1);
                    r.count_after = bag_count[hit];
                end
                else
                begin
                    slot = find_free();
                    if (slot >= 0)
                    begin
                        bag_valid[slot] = 1'b1;
                        bag_key[slot]   = it.key;
                        bag_count[slot] = COUNT_W'(1);
                        r.count_after   = COUNT_W'(1);
                    end
                    else
                        r.table_full = 1'b1;
                end
            end
            OP_REM_ONE:
            begin
                if (hit >= 0)
                begin
                    if (bag_count[hit] != '0)
                        bag_count[hit] = bag_count[hit] - COUNT_W'(1);
                    if (bag_count[hit] == '0)
                        bag_valid[hit] = 1'b0;
                    r.count_after = bag_count[hit];
                end
            end
            OP_REM_ALL:
            begin
                if (hit >= 0)
                    bag_valid[hit] = 1'b0;
            end
            default:
            begin
                if (hit >= 0)
                    r.count_after = bag_count[hit];
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one item transfer; valid stays high into the next item when its gap is
    // zero, so it is never lowered and raised within one step
    task automatic send_item(input opcode_t op, input key_t k);
        in_item_t it;
        it.opcode = op;
        it.key    = k;
        if (!valid_held)
            repeat (next_gap) @(posedge clk);
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        // transfer at this edge: predict now, in transfer order
        pending_results.push_back(predict_result(it));
        sent_count++;
        // every 40 items pick whether the next stretch idles at all
        if (sent_count % 40 == 0)
            no_idle <= ($urandom_range(0, 3) == 0);
        next_gap   = no_idle ? 0 : $urandom_range(0, 5);
        valid_held = (next_gap == 0);
        if (!valid_held)
            item_valid <= 1'b0;
    endtask

    // key not held by the bag
    function automatic key_t fresh_key();
        key_t k;
        k = $urandom;
        while (find_held(k) >= 0)
            k = $urandom;
        return k;
    endfunction

    // extremes plus random keys
    task automatic build_pool(input int n);
        key_pool.delete();
        key_pool.push_back(KEY_MIN);
        key_pool.push_back(KEY_MAX);
        key_pool.push_back(32'sd0);
        key_pool.push_back(-32'sd1);
        while (key_pool.size() < n)
            key_pool.push_back($urandom);
    endtask

    function automatic opcode_t pick_op(input int w_add, input int w_one, input int w_all);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_add)
            return OP_ADD;
        if (r < w_add + w_one)
            return OP_REM_ONE;
        if (r < w_add + w_one + w_all)
            return OP_REM_ALL;
        return OP_QUERY;
    endfunction

    task automatic send_pool_items(input int n, input int w_add, input int w_one,
                                   input int w_all);
        int i;
        for (i = 0; i < n; i++)
            send_item(pick_op(w_add, w_one, w_all),
                      key_pool[$urandom_range(0, key_pool.size() - 1)]);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes of the key, every opcode and the absent-key cases on an empty bag
    task automatic test_directed();
        send_item(OP_QUERY,   32'sd0);            // query of an absent key
        send_item(OP_REM_ONE, KEY_MIN);           // remove one, key absent
        send_item(OP_REM_ALL, KEY_MAX);           // remove all, key absent
        send_item(OP_ADD,     KEY_MIN);
        send_item(OP_ADD,     KEY_MIN);
        send_item(OP_ADD,     KEY_MAX);
        send_item(OP_ADD,     32'sd0);
        send_item(OP_ADD,     -32'sd1);
        send_item(OP_QUERY,   KEY_MIN);
        send_item(OP_QUERY,   -32'sd1);
        send_item(OP_REM_ONE, KEY_MIN);
        send_item(OP_REM_ONE, KEY_MIN);           // count hits zero, entry freed
        send_item(OP_QUERY,   KEY_MIN);
        send_item(OP_REM_ONE, KEY_MIN);
        send_item(OP_ADD,     32'sh5555_5555);    // reuses the freed lowest entry
        send_item(OP_ADD,     KEY_MIN);
        send_item(OP_REM_ALL, KEY_MAX);
        send_item(OP_QUERY,   KEY_MAX);
        send_item(OP_ADD,     32'shAAAA_AAAA);
        send_item(OP_REM_ALL, -32'sd1);
        send_item(OP_QUERY,   32'sd0);
        // the saturating count is out of reach here: it takes 2^31 - 1 adds
    endtask

    // fill every entry, then adds of new keys must report full and change nothing
    task automatic test_table_full();
        key_t k;
        key_t held [$];
        int   i;
        while (count_free() > 0)
            send_item(OP_ADD, fresh_key());
        k = fresh_key();
        send_item(OP_ADD,   k);                   // full
        send_item(OP_QUERY, k);                   // no entry was created
        send_item(OP_ADD,   bag_key[ENTRIES - 1]); // existing key still counts up
        send_item(OP_QUERY, bag_key[ENTRIES - 1]);
        send_item(OP_REM_ALL, bag_key[0]);
        send_item(OP_ADD,   fresh_key());         // lands in entry 0
        send_item(OP_REM_ONE, bag_key[10]);       // count 1, so entry 10 frees
        send_item(OP_ADD,   fresh_key());         // lands in entry 10
        send_item(OP_ADD,   fresh_key());         // full again
        send_item(OP_ADD,   k);
        // empty the bag again by remove all of every held key
        for (i = 0; i < ENTRIES; i++)
            if (bag_valid[i])
                held.push_back(bag_key[i]);
        foreach (held[j])
            send_item(OP_REM_ALL, held[j]);
    endtask

    // a dozen keys, so most items hit and counts climb
    task automatic test_random_hot_keys();
        build_pool(12);
        send_pool_items(500, 40, 25, 10);
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_results <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results <= 1'b0;
            end
            send_pool_items(150, 40, 25, 10);
        join
    endtask

    // more keys than entries and adds ahead of removes: the bag runs near full,
    // matches fall deep in the table and adds of new keys report full
    task automatic test_random_near_full();
        build_pool(ENTRIES + 8);
        send_pool_items(600, 55, 15, 10);
    endtask

    // any 32-bit key; half the items reuse a random entry's key if held, so hits occur
    task automatic test_random_any_key();
        int   i;
        int   s;
        key_t k;
        for (i = 0; i < 300; i++)
        begin
            k = $urandom;
            if ($urandom_range(0, 1) == 1)
            begin
                s = $urandom_range(0, ENTRIES - 1);
                if (bag_valid[s])
                    k = bag_key[s];
            end
            send_item(pick_op(25, 25, 25), k);
        end
    endtask

    // ------------------------------------------------------------------
    // result checker and receiver
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // checks every result transfer against the oldest prediction, then draws
    // how long the next result waits once it is offered
    initial
    begin : result_checker
        out_item_t want;
        int        stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, actual %0d/%0d/%0d",
                             $time, result.count_after, result.key_present,
                             result.table_full);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("count_after", want.count_after, result.count_after);
                    check_field("key_present", want.key_present, result.key_present);
                    check_field("table_full",  want.table_full,  result.table_full);
                end
                stall = no_idle ? 0 : $urandom_range(0, 5);
            end
            else if (result_valid && stall > 0)
                stall--;
            if (hold_results)
                result_ready <= 1'b0;
            else
                result_ready <= (stall == 0);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles without any transfer on either channel
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("[multiset_count_table_unit] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int i;
        for (i = 0; i < ENTRIES; i++)
        begin
            bag_valid[i] = 1'b0;
            bag_key[i]   = '0;
            bag_count[i] = '0;
        end

        // single reset at the start of the run
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_table_full();
        test_random_hot_keys();
        test_backpressure();
        test_random_near_full();
        test_random_any_key();

        // stop offering, let every predicted result arrive, then a quiet tail
        if (valid_held)
            item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[multiset_count_table_unit] OK");
        else
            $display("[multiset_count_table_unit] ERROR");
        $finish;
    end

endmodule

/* multiset_count_table_unit.f */
rtl/core/mct_pkg.sv
rtl/core/mct_engine.sv
rtl/core/multiset_count_table_unit.sv
dv/tb.sv
